// ===== hdl/plane_index_mixed_radix_assert.svh =====
// Assertion macros shared by the plane index converter.
`ifndef PLANE_INDEX_MIXED_RADIX_ASSERT_SVH
`define PLANE_INDEX_MIXED_RADIX_ASSERT_SVH

// Property that must hold at every clock edge once out of reset.
`define PIMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define PIMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pimr_pkg.sv =====
package pimr_pkg;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 32;

  typedef enum logic [1:0] {
    AX_Z = 2'd0,
    AX_C = 2'd1,
    AX_T = 2'd2
  } axis_t;

  typedef enum logic [1:0] {
    CFG_ORDER  = 2'd0,
    CFG_SIZE_Z = 2'd1,
    CFG_SIZE_C = 2'd2,
    CFG_SIZE_T = 2'd3
  } cfg_idx_t;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [COORD_W-1:0] coord_z;
    logic [COORD_W-1:0] coord_c;
    logic [COORD_W-1:0] coord_t;
    logic [INDEX_W-1:0] index_in;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index_out;
    logic [COORD_W-1:0] out_z;
    logic [COORD_W-1:0] out_c;
    logic [COORD_W-1:0] out_t;
    logic               range_error;
  } out_item_t;

  // Axis at nesting position 0, 1 and 2 for an order code.
  function automatic logic [5:0] nest_of(input logic [2:0] code);
    logic [5:0] r;
    begin
      unique case (code)
        3'd1:    r = {AX_C, AX_T, AX_Z};
        3'd2:    r = {AX_T, AX_Z, AX_C};
        3'd3:    r = {AX_Z, AX_T, AX_C};
        3'd4:    r = {AX_C, AX_Z, AX_T};
        3'd5:    r = {AX_Z, AX_C, AX_T};
        default: r = {AX_T, AX_C, AX_Z};
      endcase
      return r;
    end
  endfunction

endpackage

// ===== hdl/plane_index_mixed_radix.sv =====
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_stall, payload in_item
// out_    | output    | out_valid / out_stall, payload out_item
// cfg_    | input     | cfg_we, cfg_index, cfg_wdata (write only)
// One item enters per cycle while the pipeline is not stalled. A result leaves
// through 2*INDEX_BITS + 3 register stages after its item is accepted. Two
// bit-per-stage dividers in series set this depth for decode; encode rides along.
// The whole pipeline advances together; out_stall while out_valid freezes every stage.
// rst_n is synchronous, clears the valid bits and resets the configuration (order 0, lengths 1).
module plane_index_mixed_radix
  import pimr_pkg::*;
#(
  parameter int COORD_BITS = COORD_W,
  parameter int INDEX_BITS = INDEX_W
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pimr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output pimr_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  `include "plane_index_mixed_radix_assert.svh"

  localparam int CW = COORD_BITS;
  localparam int IW = INDEX_BITS;
  // Side data carried through both dividers: action, error, encode index,
  // nesting.
  localparam int HOLD_W = 1 + 1 + IW + 6;
  // The first divider also carries the zero len0 flag and len1.
  localparam int SIDE_W = HOLD_W + 1 + CW;
  // The second divider carries the first digit and both zero length flags.
  localparam int SIDE2_W = HOLD_W + CW + 2;
  // Width for the plane count compare.
  localparam int CMP_W = (IW > 3*CW) ? IW : 3*CW;

  logic [2:0]    order_r;
  logic [CW-1:0] len_r [3];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
      len_r[0] <= CW'(1);
      len_r[1] <= CW'(1);
      len_r[2] <= CW'(1);
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_ORDER:  order_r  <= cfg_wdata[2:0];
        CFG_SIZE_Z: len_r[0] <= CW'(cfg_wdata);
        CFG_SIZE_C: len_r[1] <= CW'(cfg_wdata);
        CFG_SIZE_T: len_r[2] <= CW'(cfg_wdata);
        default:    order_r  <= order_r;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: reorder, range checks, partial products.
  logic [5:0]    nest;
  logic [1:0]    a0, a1, a2;
  logic [CW-1:0] crd [3];
  logic          enc_err;
  assign nest = nest_of(order_r);
  assign a0 = nest[1:0];
  assign a1 = nest[3:2];
  assign a2 = nest[5:4];
  assign crd[0] = CW'(in_item.coord_z);
  assign crd[1] = CW'(in_item.coord_c);
  assign crd[2] = CW'(in_item.coord_t);
  assign enc_err = (crd[0] >= len_r[0]) || (crd[1] >= len_r[1]) || (crd[2] >= len_r[2]);

  logic            s1_v_r;
  logic            s1_act_r, s1_err_r;
  logic [5:0]      s1_nest_r;
  logic [CW-1:0]   s1_len0_r, s1_len1_r, s1_v0_r, s1_v2_r;
  logic [2*CW-1:0] s1_p1_r, s1_l01_r, s1_zc_r;
  logic [CW-1:0]   s1_lt_r;
  logic [IW-1:0]   s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_v_r <= 1'b0;
    else if (adv) s1_v_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_act_r  <= in_item.action;
      s1_err_r  <= enc_err;
      s1_nest_r <= nest;
      s1_len0_r <= len_r[a0];
      s1_len1_r <= len_r[a1];
      s1_v0_r   <= crd[a0];
      s1_v2_r   <= crd[a2];
      s1_p1_r   <= crd[a1] * len_r[a0];
      s1_l01_r  <= len_r[a0] * len_r[a1];
      s1_zc_r   <= len_r[0] * len_r[1];
      s1_lt_r   <= len_r[2];
      s1_idx_r  <= IW'(in_item.index_in);
    end
  end

  // Stage 2: second product layer and the plane count compare.
  logic [3*CW-1:0] pc;
  logic            dec_err;
  assign pc      = s1_zc_r * s1_lt_r;
  assign dec_err = CMP_W'(s1_idx_r) >= CMP_W'(pc);

  logic            s2_v_r, s2_act_r, s2_err_r;
  logic [5:0]      s2_nest_r;
  logic [CW-1:0]   s2_len0_r, s2_len1_r;
  logic [IW-1:0]   s2_idx_r, s2_enc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s2_v_r <= 1'b0;
    else if (adv) s2_v_r <= s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_act_r  <= s1_act_r;
      s2_err_r  <= (s1_act_r == ACT_DECODE) ? dec_err : s1_err_r;
      s2_nest_r <= s1_nest_r;
      s2_len0_r <= s1_len0_r;
      s2_len1_r <= s1_len1_r;
      s2_idx_r  <= s1_idx_r;
      s2_enc_r  <= IW'(s1_v0_r) + IW'(s1_p1_r) + IW'(s1_v2_r * s1_l01_r);
    end
  end

  // Two chained dividers: idx / len0, then quotient / len1.
  logic [SIDE_W-1:0] side1, side1_o;
  logic              d1_v, d2_v;
  logic [IW-1:0]     q1, q2;
  logic [CW-1:0]     r1, r2;
  assign side1 = {s2_act_r, s2_err_r, s2_enc_r, s2_nest_r, (s2_len0_r == '0), s2_len1_r};

  pimr_divider #(.NUM_W(IW), .DEN_W(CW), .SIDE_W(SIDE_W)) u_div0 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_in(s2_v_r), .num_in(s2_idx_r),
    .den_in(s2_len0_r), .side_in(side1), .v_out(d1_v), .quo_out(q1),
    .rem_out(r1), .side_out(side1_o)
  );

  logic [HOLD_W-1:0]  hold1;
  logic               z0_o;
  logic [CW-1:0]      len1_o;
  logic [SIDE2_W-1:0] side2, s2o;
  assign {hold1, z0_o, len1_o} = side1_o;
  // A zero length on either inner axis forces all decoded coordinates to zero.
  assign side2 = {hold1, r1, (len1_o == '0), z0_o};

  pimr_divider #(.NUM_W(IW), .DEN_W(CW), .SIDE_W(SIDE2_W)) u_div1 (
    .clk(clk), .rst_n(rst_n), .adv(adv), .v_in(d1_v), .num_in(q1),
    .den_in(len1_o), .side_in(side2), .v_out(d2_v), .quo_out(q2),
    .rem_out(r2), .side_out(s2o)
  );

  // Output stage: place the three digits back on their axes.
  logic          o_act, o_err, z1, zl0;
  logic [IW-1:0] o_enc;
  logic [5:0]    o_nest;
  logic [CW-1:0] o_v0;
  logic [CW-1:0] v [3];
  logic [CW-1:0] cz [3];
  assign {o_act, o_err, o_enc, o_nest, o_v0, z1, zl0} = s2o;

  always_comb begin
    v[0] = o_v0;
    v[1] = r2;
    v[2] = CW'(q2);
    if (z1 || zl0) begin
      v[0] = '0;
      v[1] = '0;
      v[2] = '0;
    end
    cz[0] = '0;
    cz[1] = '0;
    cz[2] = '0;
    cz[o_nest[1:0]] = v[0];
    cz[o_nest[3:2]] = v[1];
    cz[o_nest[5:4]] = v[2];
  end

  logic      ov_r;
  out_item_t oi_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (adv) ov_r <= d2_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      oi_r.range_error <= o_err;
      if (o_act == ACT_DECODE) begin
        oi_r.index_out <= '0;
        oi_r.out_z <= COORD_W'(cz[0]);
        oi_r.out_c <= COORD_W'(cz[1]);
        oi_r.out_t <= COORD_W'(cz[2]);
      end else begin
        oi_r.index_out <= INDEX_W'(o_enc);
        oi_r.out_z <= '0;
        oi_r.out_c <= '0;
        oi_r.out_t <= '0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

  `PIMR_ASSERT(a_stall_eq, in_stall == (out_valid && out_stall), "stall mismatch")
  `PIMR_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_item),
    "held item changed")
  `PIMR_ASSERT(a_enc_zero, !out_valid || out_item.index_out == '0 ||
    (out_item.out_z == '0 && out_item.out_c == '0 && out_item.out_t == '0),
    "both result kinds set")
endmodule

// ===== hdl/pimr_divstage.sv =====
// One restoring division step per pipeline stage, with stall and valid.
module pimr_divstage #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              v_in,
  input  logic [NUM_W-1:0]  q_in,
  input  logic [DEN_W:0]    r_in,
  input  logic [DEN_W-1:0]  d_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [NUM_W-1:0]  q_out,
  output logic [DEN_W:0]    r_out,
  output logic [DEN_W-1:0]  d_out,
  output logic [SIDE_W-1:0] side_out
);
  logic              v_r;
  logic [NUM_W-1:0]  q_r, q_nxt;
  logic [DEN_W:0]    r_r, r_nxt;
  logic [DEN_W-1:0]  d_r;
  logic [SIDE_W-1:0] side_r;
  logic [DEN_W+1:0]  trial;
  logic [DEN_W+1:0]  diff;

  // Shift the next numerator bit in and subtract the divisor when it fits.
  always_comb begin
    trial = {r_in, q_in[NUM_W-1]};
    diff  = trial - {2'b00, d_in};
    if (!diff[DEN_W+1]) begin
      r_nxt = diff[DEN_W:0];
      q_nxt = {q_in[NUM_W-2:0], 1'b1};
    end else begin
      r_nxt = trial[DEN_W:0];
      q_nxt = {q_in[NUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_r    <= q_nxt;
      r_r    <= r_nxt;
      d_r    <= d_in;
      side_r <= side_in;
    end
  end

  assign v_out    = v_r;
  assign q_out    = q_r;
  assign r_out    = r_r;
  assign d_out    = d_r;
  assign side_out = side_r;
endmodule

// ===== hdl/pimr_divider.sv =====
// Pipelined unsigned divider, one quotient bit per stage.
module pimr_divider #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              v_in,
  input  logic [NUM_W-1:0]  num_in,
  input  logic [DEN_W-1:0]  den_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [NUM_W-1:0]  quo_out,
  output logic [DEN_W-1:0]  rem_out,
  output logic [SIDE_W-1:0] side_out
);
  logic              v_s [NUM_W+1];
  logic [NUM_W-1:0]  q_s [NUM_W+1];
  logic [DEN_W:0]    r_s [NUM_W+1];
  logic [DEN_W-1:0]  d_s [NUM_W+1];
  logic [SIDE_W-1:0] s_s [NUM_W+1];

  assign v_s[0] = v_in;
  assign q_s[0] = num_in;
  assign r_s[0] = '0;
  assign d_s[0] = den_in;
  assign s_s[0] = side_in;

  for (genvar g = 0; g < NUM_W; g++) begin : g_step
    pimr_divstage #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(SIDE_W)) u_step (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .v_in(v_s[g]), .q_in(q_s[g]), .r_in(r_s[g]), .d_in(d_s[g]),
      .side_in(s_s[g]),
      .v_out(v_s[g+1]), .q_out(q_s[g+1]), .r_out(r_s[g+1]), .d_out(d_s[g+1]),
      .side_out(s_s[g+1])
    );
  end

  assign v_out    = v_s[NUM_W];
  assign quo_out  = q_s[NUM_W];
  assign rem_out  = r_s[NUM_W][DEN_W-1:0];
  assign side_out = s_s[NUM_W];
endmodule
